### rtl/core/sorted_table_binary_search_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted table binary search unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit: package
// Types, constants and codes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Default table depth and fixed field widths.
    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned VALUE_BITS      = 32;
    localparam int unsigned POS_BITS        = 10;
    localparam int unsigned SIZE_BITS       = 11;

    // Configuration port geometry and register map.
    localparam int unsigned APB_ADDR_BITS = 2;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_TABLE_SIZE = 2'd0;

    // Item command codes.
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } stbs_cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE,
        ST_DONE
    } stbs_state_t;

    // Input item.
    typedef struct packed {
        stbs_cmd_t                     command;
        logic [POS_BITS-1:0]           position;
        logic signed [VALUE_BITS-1:0]  value;
    } stbs_req_t;

    // Result item.
    typedef struct packed {
        logic                 found;
        logic [POS_BITS-1:0]  match_position;
    } stbs_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_write;
        logic capture;
        logic probe;
        logic update;
    } stbs_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic hit;
    } stbs_stat_t;

endpackage

### rtl/core/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// Loads a sorted table of signed values and searches it for a key.
// ----------------------------------------------------------------------------
// A load item (command 0) is written into the table at the edge it is taken
// and busy stays low, so loads can be issued every cycle and give no result.
// A search item (command 1) probes midpoints of the first table_size entries
// (at most TABLE_DEPTH); each probe takes a check state for the synchronous
// table read and a compare state for the compare. The search ends in the done
// state after a compare that hits or after a check that finds no entries left,
// and busy drops in the cycle after done; a 1024-entry table needs at most 11
// probes. done is high for one cycle and the result must be taken then: there
// is no way to hold it. match_position is 0 whenever found is 0. Write table_size
// only while busy is low; entries a search may probe must have been loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit
    import stbs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  stbs_req_t                 request,
    output logic                      done,
    output stbs_rsp_t                 result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    logic [SIZE_BITS-1:0] table_size;
    stbs_ctl_t            ctl;
    stbs_stat_t           stat;

    // Configuration registers.
    stbs_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .table_size (table_size)
    );

    // Sequencer.
    stbs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    // Table and search datapath.
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .request    (request),
        .table_size (table_size),
        .ctl        (ctl),
        .stat       (stat),
        .result     (result)
    );

endmodule

### rtl/core/stbs_cfg.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit: configuration registers
// APB-style register file holding the table size.
// ----------------------------------------------------------------------------
module stbs_cfg
    import stbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    output logic [SIZE_BITS-1:0]      table_size
);

    logic [SIZE_BITS-1:0] table_size_reg;
    logic                 wr_en;

    // A write completes in the access phase; the port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TABLE_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
        end
        else if (wr_en)
        begin
            table_size_reg <= pwdata[SIZE_BITS-1:0];
        end
    end

    // Read back the register; unmapped addresses read as zero.
    always_comb
    begin
        if (paddr == ADDR_TABLE_SIZE)
        begin
            prdata = APB_DATA_BITS'(table_size_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign table_size = table_size_reg;

endmodule

### rtl/core/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit: controller
// State machine that sequences loads, probes and the result strobe.
// ----------------------------------------------------------------------------
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  stbs_cmd_t   command,
    input  stbs_stat_t  stat,
    output stbs_ctl_t   ctl,
    output logic        busy,
    output logic        done
);

    stbs_state_t state_reg;
    stbs_state_t state_next;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: each probe takes a check state and a compare state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_SEARCH))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.in_range)
                begin
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COMPARE:
            begin
                if (stat.hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: datapath commands and the handshake signals.
    always_comb
    begin
        ctl            = '0;
        busy           = 1'b1;
        done           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                ctl.load_write = accept && (command == CMD_LOAD);
                ctl.capture    = accept && (command == CMD_SEARCH);
            end
            ST_CHECK:
            begin
                ctl.probe = stat.in_range;
            end
            ST_COMPARE:
            begin
                ctl.update = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/stbs_dp.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit: datapath
// Table memory, search bounds, midpoint, key compare and result registers.
// ----------------------------------------------------------------------------
module stbs_dp
    import stbs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  stbs_req_t             request,
    input  logic [SIZE_BITS-1:0]  table_size,
    input  stbs_ctl_t             ctl,
    output stbs_stat_t            stat,
    output stbs_rsp_t             result
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [VALUE_BITS-1:0] table_mem [TABLE_DEPTH];

    logic signed [VALUE_BITS-1:0] key_reg;
    logic signed [VALUE_BITS-1:0] rdata_reg;
    logic [SIZE_BITS-1:0]         low_reg;
    logic [SIZE_BITS-1:0]         low_next;
    logic [SIZE_BITS-1:0]         top_reg;     // one past the high bound
    logic [SIZE_BITS-1:0]         top_next;
    logic                         found_reg;
    logic                         found_next;
    logic [POS_BITS-1:0]          match_reg;
    logic [POS_BITS-1:0]          match_next;

    logic [SIZE_BITS-1:0]         size_eff;
    logic [SIZE_BITS:0]           mid_sum;
    logic [SIZE_BITS-1:0]         mid;
    logic                         pos_ok;

    // Search covers no more entries than the table holds.
    assign size_eff = (32'(table_size) > TABLE_DEPTH) ? SIZE_BITS'(TABLE_DEPTH) : table_size;

    // Midpoint of low and high, with high kept as one past the bound.
    assign mid_sum = {1'b0, low_reg} + {1'b0, top_reg} - {{SIZE_BITS{1'b0}}, 1'b1};
    assign mid     = mid_sum[SIZE_BITS:1];

    assign pos_ok  = 32'(request.position) < TABLE_DEPTH;

    // Table memory: one write port for loads, one registered read for probes.
    always_ff @(posedge clk)
    begin
        if (ctl.load_write && pos_ok)
        begin
            table_mem[ADDR_W'(request.position)] <= request.value;
        end
        if (ctl.probe)
        begin
            rdata_reg <= table_mem[ADDR_W'(mid)];
        end
    end

    // Status back to the controller.
    assign stat.in_range = low_reg < top_reg;
    assign stat.hit      = key_reg == rdata_reg;

    // Set the bounds when a search is captured, then narrow them or record the hit after each probe.
    always_comb
    begin
        low_next   = low_reg;
        top_next   = top_reg;
        found_next = found_reg;
        match_next = match_reg;
        if (ctl.capture)
        begin
            low_next   = '0;
            top_next   = size_eff;
            found_next = 1'b0;
            match_next = '0;
        end
        else if (ctl.update)
        begin
            if (key_reg == rdata_reg)
            begin
                found_next = 1'b1;
                match_next = mid[POS_BITS-1:0];
            end
            else if (key_reg > rdata_reg)
            begin
                low_next = mid + SIZE_BITS'(1);
            end
            else
            begin
                top_next = mid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            key_reg <= request.value;
        end
        low_reg   <= low_next;
        top_reg   <= top_next;
        found_reg <= found_next;
        match_reg <= match_next;
    end

    assign result.found          = found_reg;
    assign result.match_position = match_reg;

endmodule

### rtl/core/stbs_chk.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit: port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_unit_macros.svh"

module stbs_chk
    import stbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  stbs_req_t                 request,
    input  logic                      done,
    input  stbs_rsp_t                 result
);

    logic take_search;
    logic take_load;

    assign take_search = start && !busy && (request.command == CMD_SEARCH);
    assign take_load   = start && !busy && (request.command == CMD_LOAD);

    // A result only comes out of a search that is in progress.
    `STBS_ASSERT_SAME(a_done_in_search, done, busy && $past(busy), "result outside a search")

    // A miss reports position zero.
    `STBS_ASSERT_SAME(a_miss_pos_zero, done && !result.found, result.match_position == '0, "miss with nonzero position")

    // One result per search: the strobe is never extended, and busy is low once it drops.
    `STBS_ASSERT_NEXT(a_single_strobe, done, !done && !busy, "result strobe longer than one cycle")

    // A taken search occupies the block; a taken load does not.
    `STBS_ASSERT_NEXT(a_search_busy, take_search, busy && !done, "search not started")
    `STBS_ASSERT_NEXT(a_load_quiet, take_load, !busy && !done, "load produced activity")

endmodule

bind sorted_table_binary_search_unit stbs_chk u_stbs_chk (.*);

### bench/stbs_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search unit: result checker
// Watches the item, result and register ports. It keeps its own copy of the
// table and of table_size, works out the result of every accepted search and
// compares each result that comes back with the oldest one still awaited.
// ----------------------------------------------------------------------------
module stbs_search_checker
    import stbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  stbs_req_t                 request,
    input  logic                      done,
    input  stbs_rsp_t                 result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    input  logic [APB_DATA_BITS-1:0]  prdata,
    input  logic                      pready,
    output int                        mismatches,
    output int                        outstanding
);

    // Local copy of the table contents and of the size register.
    logic signed [VALUE_BITS-1:0] table_mirror [TABLE_DEPTH_DEF];
    logic [SIZE_BITS-1:0]         mirror_size;

    // Results of accepted searches that have not come back yet.
    stbs_rsp_t awaited_results [$];

    // Walks the probe sequence over the mirrored table for one key.
    function automatic stbs_rsp_t search_outcome(input logic signed [VALUE_BITS-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        stbs_rsp_t outcome;
        lo      = 0;
        hi      = (mirror_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF - 1 : int'(mirror_size) - 1;
        outcome = '0;
        while (lo <= hi && !outcome.found) begin
            mid = (lo + hi) / 2;
            if (key == table_mirror[mid]) begin
                outcome.found          = 1'b1;
                outcome.match_position = mid[POS_BITS-1:0];
            end
            else if (key > table_mirror[mid]) begin
                lo = mid + 1;
            end
            else begin
                hi = mid - 1;
            end
        end
        return outcome;
    endfunction

    // Counts a mismatch and tells whether it is still among those reported.
    function automatic bit log_mismatch();
        mismatches++;
        return (mismatches <= 10);
    endfunction

    initial begin
        mismatches  = 0;
        outstanding = 0;
        mirror_size = '0;
    end

    always @(posedge clk or negedge rst_n) begin
        stbs_rsp_t want;
        if (!rst_n) begin
            awaited_results.delete();
            outstanding = 0;
            mirror_size = '0;
        end
        else begin
            // Register port: track writes and check read data.
            if (psel && penable && pready && paddr == ADDR_TABLE_SIZE) begin
                if (pwrite) begin
                    mirror_size = pwdata[SIZE_BITS-1:0];
                end
                else if (prdata != APB_DATA_BITS'(mirror_size)) begin
                    if (log_mismatch())
                        $display("table_size read: expected %0d, got %0d", mirror_size, prdata);
                end
            end

            // Each result is compared with the oldest awaited one.
            if (done) begin
                if (awaited_results.size() == 0) begin
                    if (log_mismatch())
                        $display("result with no search waiting: found %0b position %0d",
                                 result.found, result.match_position);
                end
                else begin
                    want = awaited_results.pop_front();
                    outstanding = awaited_results.size();
                    if (result.found != want.found
                        || result.match_position != want.match_position) begin
                        if (log_mismatch())
                            $display("search result: expected found %0b position %0d, got found %0b position %0d",
                                     want.found, want.match_position,
                                     result.found, result.match_position);
                    end
                end
            end

            // Accepted item: a load updates the copy, a search is predicted.
            if (start && !busy) begin
                if (request.command == CMD_LOAD) begin
                    table_mirror[request.position] = request.value;
                end
                else begin
                    awaited_results = {awaited_results, search_outcome(request.value)};
                    outstanding = awaited_results.size();
                end
            end
        end
    end

endmodule

### bench/tb_sorted_table_binary_search_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search unit: testbench
// Loads sorted tables of several sizes, from empty to oversized, and searches
// them with keys taken from the table, next to it, at the extremes and at
// random, with stray loads mixed in. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_unit;
    import stbs_pkg::*;

    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    // Settling wait that drain() adds after the last awaited result.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    stbs_req_t                 request;
    logic                      done;
    stbs_rsp_t                 result;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit quiet = 1'b0;

    // Values the stimulus has loaded, used to pick search keys.
    logic signed [VALUE_BITS-1:0] loaded_vals [TABLE_DEPTH_DEF];

    always #5 clk = ~clk;

    sorted_table_binary_search_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stbs_search_checker search_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Run time guard.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one item, after an optional random gap, and waits until taken.
    task automatic issue_item(input stbs_cmd_t cmd, input logic [POS_BITS-1:0] pos,
                              input logic signed [VALUE_BITS-1:0] val);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= {cmd, pos, val};
        @(posedge clk);
        while (busy) @(posedge clk);
        if (cmd == CMD_LOAD)
            loaded_vals[pos] = val;
    endtask

    // Stops offering items and lets every awaited result come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register port transfer: setup cycle, then access cycle.
    task automatic apb_transfer(input bit wr, input logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes table_size once the block is idle and reads it back.
    task automatic program_table_size(input logic [APB_DATA_BITS-1:0] data);
        drain();
        apb_transfer(1'b1, data);
        apb_transfer(1'b0, '0);
    endtask

    // One random phase: set the size, load a sorted table, then search it.
    task automatic run_phase(input logic [APB_DATA_BITS-1:0] size_word, input int count,
                             input bit calm);
        int                            n;
        int                            p;
        int                            r;
        int unsigned                   span;
        longint                        cur;
        longint                        step;
        bit                            dense;
        logic signed [VALUE_BITS-1:0]  key;
        program_table_size(size_word);
        n = int'(size_word[SIZE_BITS-1:0]);
        if (n > TABLE_DEPTH_DEF)
            n = TABLE_DEPTH_DEF;

        // Ascending values; dense steps give runs of repeated values.
        dense = $urandom_range(0, 1);
        span  = (n > 0) ? 32'hFFFF_FFFF / n : 32'hFFFF_FFFF;
        if ($urandom_range(0, 3) == 0)
            cur = longint'(VAL_MIN);
        else
            cur = longint'(VAL_MIN) + $urandom_range(0, 32'h7FFF_FFFF);
        for (int i = 0; i < n; i++) begin
            issue_item(CMD_LOAD, POS_BITS'(i), cur[VALUE_BITS-1:0]);
            step = dense ? $urandom_range(0, 2) : $urandom_range(0, span);
            cur  = cur + step;
            if (cur > longint'(VAL_MAX))
                cur = longint'(VAL_MAX);
        end

        quiet = calm;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            p = (n > 0) ? $urandom_range(0, n - 1) : 0;
            if (r < 10) begin
                // Stray load: may break the ordering of the table.
                issue_item(CMD_LOAD, POS_BITS'($urandom), VALUE_BITS'($urandom));
            end
            else begin
                if (n == 0 || r >= 90)
                    key = VALUE_BITS'($urandom);
                else if (r < 60)
                    key = loaded_vals[p];
                else if (r < 80)
                    key = $urandom_range(0, 1) ? loaded_vals[p] + 1 : loaded_vals[p] - 1;
                else
                    key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
                issue_item(CMD_SEARCH, POS_BITS'($urandom), key);
            end
        end
        quiet = 1'b0;
    endtask

    // Large-table phase: only the top levels of the probe tree and both outer
    // spines are loaded, in ascending order. Keys are loaded values or the
    // extremes, so every search stays on loaded entries.
    task automatic run_tree_phase(input logic [APB_DATA_BITS-1:0] size_word,
                                  input int levels, input int count);
        int                            n;
        int                            lo;
        int                            hi;
        int                            mid;
        int                            cnt;
        int                            lo_q [$];
        int                            hi_q [$];
        int                            nodes [$];
        bit                            picked [TABLE_DEPTH_DEF];
        longint                        cur;
        logic signed [VALUE_BITS-1:0]  key;
        program_table_size(size_word);
        n = int'(size_word[SIZE_BITS-1:0]);
        if (n > TABLE_DEPTH_DEF)
            n = TABLE_DEPTH_DEF;
        picked = '{default: 1'b0};

        // Top levels of the probe tree, one level at a time.
        lo_q = {0};
        hi_q = {n - 1};
        for (int lv = 0; lv < levels; lv++) begin
            cnt = lo_q.size();
            for (int k = 0; k < cnt; k++) begin
                lo = lo_q.pop_front();
                hi = hi_q.pop_front();
                if (lo <= hi) begin
                    mid         = (lo + hi) / 2;
                    picked[mid] = 1'b1;
                    lo_q        = {lo_q, lo, mid + 1};
                    hi_q        = {hi_q, mid - 1, hi};
                end
            end
        end

        // Left and right spines, taken by keys beyond either end.
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid         = (lo + hi) / 2;
            picked[mid] = 1'b1;
            hi          = mid - 1;
        end
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid         = (lo + hi) / 2;
            picked[mid] = 1'b1;
            lo          = mid + 1;
        end

        // Ascending values at the chosen positions only.
        cur = longint'(VAL_MIN) + $urandom_range(0, 255);
        for (int i = 0; i < n; i++) begin
            if (picked[i]) begin
                issue_item(CMD_LOAD, POS_BITS'(i), cur[VALUE_BITS-1:0]);
                nodes = {nodes, i};
                cur   = cur + $urandom_range(1, 32'h0100_0000);
                if (cur > longint'(VAL_MAX))
                    cur = longint'(VAL_MAX);
            end
        end

        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            else
                key = loaded_vals[nodes[$urandom_range(0, nodes.size() - 1)]];
            issue_item(CMD_SEARCH, POS_BITS'($urandom), key);
        end
    endtask

    initial begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, first with the reset size, then with size written as 0.
        issue_item(CMD_SEARCH, 10'd0, 32'sd0);
        program_table_size(32'd0);
        issue_item(CMD_SEARCH, 10'h3FF, VAL_MIN);

        // Five entries spanning the whole value range.
        program_table_size(32'd5);
        issue_item(CMD_LOAD, 10'd0, VAL_MIN);
        issue_item(CMD_LOAD, 10'd1, -32'sd1);
        issue_item(CMD_LOAD, 10'd2, 32'sd0);
        issue_item(CMD_LOAD, 10'd3, 32'sd1);
        issue_item(CMD_LOAD, 10'd4, VAL_MAX);
        issue_item(CMD_SEARCH, 10'h155, VAL_MIN);
        issue_item(CMD_SEARCH, 10'h2AA, VAL_MAX);
        issue_item(CMD_SEARCH, 10'd0, 32'sd0);
        issue_item(CMD_SEARCH, 10'd0, -32'sd1);
        issue_item(CMD_SEARCH, 10'd0, 32'sd1);
        issue_item(CMD_SEARCH, 10'd0, 32'sd2);
        issue_item(CMD_SEARCH, 10'd0, -32'sd2);

        // Repeated values: the first midpoint that hits is reported.
        issue_item(CMD_LOAD, 10'd1, 32'sd7);
        issue_item(CMD_LOAD, 10'd2, 32'sd7);
        issue_item(CMD_LOAD, 10'd3, 32'sd7);
        issue_item(CMD_SEARCH, 10'd0, 32'sd7);
        issue_item(CMD_SEARCH, 10'd0, 32'sd8);

        // Unsorted table: the probe sequence misses the first entry.
        issue_item(CMD_LOAD, 10'd0, 32'sd100);
        issue_item(CMD_SEARCH, 10'd0, 32'sd100);

        // Random phases over small and medium sizes.
        run_phase(32'd1, 20, 1'b0);
        run_phase($urandom_range(2, 16), 40, 1'b0);
        run_phase($urandom_range(17, 60), 45, 1'b1);
        run_phase($urandom_range(3, 40), 30, 1'b0);

        // Full-depth, oversized and just-under-full sizes over a partly loaded table.
        run_tree_phase(32'hFFFF_FFFF, 4, 12);
        run_tree_phase(32'd1024, 4, 20);
        run_tree_phase({21'($urandom), 11'd1025}, 4, 12);
        run_tree_phase(32'd1023, 4, 15);

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/stbs_pkg.sv
rtl/core/stbs_cfg.sv
rtl/core/stbs_ctrl.sv
rtl/core/stbs_dp.sv
rtl/core/sorted_table_binary_search_unit.sv
rtl/core/stbs_chk.sv
bench/stbs_search_checker.sv
bench/tb_sorted_table_binary_search_unit.sv
